// ===== rtl/double_ended_queue_engine_unit_assert.svh =====
// Assertion macros for the deque engine. The scope that uses them provides clk and rst_n.
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue engine.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 4;
  localparam int CNT_W  = 6;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_FRONT      = 4'd4;
  localparam logic [FUNC_W-1:0] FN_BACK       = 4'd5;
  localparam logic [FUNC_W-1:0] FN_EMPTY      = 4'd6;
  localparam logic [FUNC_W-1:0] FN_SIZE       = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;
  localparam logic [FUNC_W-1:0] FN_REVERSE    = 4'd9;
  localparam logic [FUNC_W-1:0] FN_SORT       = 4'd10;
  localparam logic [FUNC_W-1:0] FN_LIST       = 4'd11;

  // Pointer and counter operations
  localparam logic [1:0] HEAD_HOLD = 2'd0;
  localparam logic [1:0] HEAD_DEC  = 2'd1;
  localparam logic [1:0] HEAD_INC  = 2'd2;
  localparam logic [1:0] HEAD_ZERO = 2'd3;

  localparam logic [1:0] OCC_HOLD = 2'd0;
  localparam logic [1:0] OCC_INC  = 2'd1;
  localparam logic [1:0] OCC_DEC  = 2'd2;
  localparam logic [1:0] OCC_ZERO = 2'd3;

  localparam logic [1:0] I_HOLD = 2'd0;
  localparam logic [1:0] I_ZERO = 2'd1;
  localparam logic [1:0] I_ONE  = 2'd2;
  localparam logic [1:0] I_INC  = 2'd3;

  localparam logic [1:0] J_HOLD   = 2'd0;
  localparam logic [1:0] J_LAST   = 2'd1;
  localparam logic [1:0] J_FROM_I = 2'd2;
  localparam logic [1:0] J_DEC    = 2'd3;

  // Memory address sources
  localparam logic [2:0] ADDR_NEWHEAD = 3'd0;
  localparam logic [2:0] ADDR_TAIL    = 3'd1;
  localparam logic [2:0] ADDR_BACK    = 3'd2;
  localparam logic [2:0] ADDR_HEAD    = 3'd3;
  localparam logic [2:0] ADDR_I       = 3'd4;
  localparam logic [2:0] ADDR_J       = 3'd5;
  localparam logic [2:0] ADDR_JM1     = 3'd6;

  // Write data sources
  localparam logic [1:0] WD_VALUE = 2'd0;
  localparam logic [1:0] WD_RDATA = 2'd1;
  localparam logic [1:0] WD_TMP   = 2'd2;
  localparam logic [1:0] WD_KEY   = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       drop_set;
    logic       mem_rd;
    logic       mem_wr;
    logic [2:0] addr_sel;
    logic [1:0] wdata_sel;
    logic       tmp_load;
    logic       key_load;
    logic [1:0] head_op;
    logic [1:0] occ_op;
    logic [1:0] i_op;
    logic [1:0] j_op;
    logic       out_load;
    logic       out_list;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              occ_gt1;
    logic              key_less;
    logic              rev_more;
    logic              sort_more;
    logic              j_is1;
    logic              list_last;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/double_ended_queue_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_engine_unit
// Double-ended queue of signed words in a circular store, with reverse,
// sort and list commands.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser               | tlast
// in_     | in  | value[31:0]                    | func[3:0]           | -
// out_    | out | data[31:0], count[37:32], pad  | is_empty, dropped   | last
//
// Push, pop, front, back, empty, size, clear: accept, dispatch, emit;
// dispatch does any store access. Reverse: per pair, read i, read j, write
// i, write j. Sort: per key, read and load it, then read and compare per
// shift, then place it. List: read and transfer each word in turn.
// Reset is synchronous, active low; store contents are not cleared.
// A stalled output holds the sequencer in its emit or list step; a new command
// is taken only once the previous one has loaded its last result.
// ----------------------------------------------------------------------------
module double_ended_queue_engine_unit
  import deq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [3:0]  in_tuser,   // func[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data[31:0], count[37:32], zero [39:38]
  output logic [1:0]  out_tuser,  // is_empty[0], dropped[1]
  output logic        out_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_count;
  logic              out_is_empty, out_dropped;

  // Sequencer: one command in flight at a time.
  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Store, pointers and output register.
  deq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_tuser),
    .in_value    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_data),
    .out_count   (out_count),
    .out_is_empty(out_is_empty),
    .out_dropped (out_dropped),
    .out_last    (out_tlast)
  );

  // Pack fields lowest first, pad tdata to whole bytes.
  assign out_tdata = {2'b00, out_count, out_data};
  assign out_tuser = {out_dropped, out_is_empty};

endmodule

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: store, head and occupancy, walk indices and the output register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_engine_unit_assert.svh"
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_value,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_is_empty,
  output logic              out_dropped,
  output logic              out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] value_r, tmp_r, key_r;
  logic              drop_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [AW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]     addr, occm1, jm1;
  logic [DATA_W-1:0] wdata, rdata, emit_data;
  logic              empty;
  logic [CW+DATA_W-1:0] occ_ext;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_empty_r, out_drop_r, out_last_r;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign empty   = (occ_r == '0);
  assign occm1   = AW'(occ_r - CW'(1));
  assign jm1     = j_r - AW'(1);
  assign occ_ext = {{DATA_W{1'b0}}, occ_r};

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_NEWHEAD: addr = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
      ADDR_TAIL:    addr = slot(head_r, occ_r[AW-1:0]);
      ADDR_BACK:    addr = slot(head_r, occm1);
      ADDR_HEAD:    addr = head_r;
      ADDR_I:       addr = slot(head_r, i_r);
      ADDR_J:       addr = slot(head_r, j_r);
      ADDR_JM1:     addr = slot(head_r, jm1);
      default:      addr = head_r;
    endcase
  end

  always_comb begin
    case (cmd.wdata_sel)
      WD_VALUE: wdata = value_r;
      WD_RDATA: wdata = rdata;
      WD_TMP:   wdata = tmp_r;
      default:  wdata = key_r;
    endcase
  end

  deq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (cmd.mem_wr),
    .waddr(addr),
    .wdata(wdata),
    .re   (cmd.mem_rd),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    case (cmd.head_op)
      HEAD_DEC:  head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
      HEAD_INC:  head_nxt = slot(head_r, AW'(1));
      HEAD_ZERO: head_nxt = '0;
      default:   head_nxt = head_r;
    endcase
    case (cmd.occ_op)
      OCC_INC:  occ_nxt = occ_r + CW'(1);
      OCC_DEC:  occ_nxt = occ_r - CW'(1);
      OCC_ZERO: occ_nxt = '0;
      default:  occ_nxt = occ_r;
    endcase
    case (cmd.i_op)
      I_ZERO:  i_nxt = '0;
      I_ONE:   i_nxt = AW'(1);
      I_INC:   i_nxt = i_r + AW'(1);
      default: i_nxt = i_r;
    endcase
    case (cmd.j_op)
      J_LAST:   j_nxt = occm1;
      J_FROM_I: j_nxt = i_r;
      J_DEC:    j_nxt = jm1;
      default:  j_nxt = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // Walk indices and holding registers carry payload only.
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (cmd.load_in) begin
      func_r  <= in_func;
      value_r <= in_value;
    end
    if (cmd.tmp_load) begin
      tmp_r <= rdata;
    end
    if (cmd.key_load) begin
      key_r <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (cmd.load_in) begin
      drop_r <= 1'b0;
    end else if (cmd.drop_set) begin
      drop_r <= 1'b1;
    end
  end

  // Single-item result value by command.
  always_comb begin
    case (func_r) inside
      FN_FRONT, FN_BACK: emit_data = empty ? '1 : rdata;
      FN_EMPTY:          emit_data = {{(DATA_W-1){1'b0}}, empty};
      FN_SIZE:           emit_data = occ_ext[DATA_W-1:0];
      FN_LIST:           emit_data = '1;
      default:           emit_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r  <= cmd.out_list ? rdata : emit_data;
      out_cnt_r   <= occ_ext[CNT_W-1:0];
      out_empty_r <= empty;
      out_drop_r  <= drop_r;
      out_last_r  <= cmd.out_list ? sts.list_last : 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_count    = out_cnt_r;
  assign out_is_empty = out_empty_r;
  assign out_dropped  = out_drop_r;
  assign out_last     = out_last_r;

  assign sts.func      = func_r;
  assign sts.full      = (occ_r == CW'(DEPTH));
  assign sts.empty     = empty;
  assign sts.occ_gt1   = (occ_r > CW'(1));
  assign sts.key_less  = ($signed(key_r) < $signed(rdata));
  assign sts.rev_more  = (({1'b0, i_r} + (AW+1)'(1)) < ({1'b0, j_r} - (AW+1)'(1)));
  assign sts.sort_more = (((CW+1)'(i_r) + (CW+1)'(1)) < (CW+1)'(occ_r));
  assign sts.j_is1     = (j_r == AW'(1));
  assign sts.list_last = (((CW+1)'(i_r) + (CW+1)'(1)) == (CW+1)'(occ_r));
  assign sts.out_free  = !out_valid_r || out_ready;

  `DEQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_one_access, cmd.mem_wr, !cmd.mem_rd)
  `DEQ_ASSERT_NOW(a_no_push_full, cmd.occ_op == OCC_INC, occ_r < CW'(DEPTH))
  `DEQ_ASSERT_NEXT(a_head_hold, cmd.head_op == HEAD_HOLD, $stable(head_r))

endmodule

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: decodes a command and steps the datapath through it.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_EMIT  = 4'd2;
  localparam logic [3:0] ST_R1    = 4'd3;
  localparam logic [3:0] ST_R2    = 4'd4;
  localparam logic [3:0] ST_R3    = 4'd5;
  localparam logic [3:0] ST_R4    = 4'd6;
  localparam logic [3:0] ST_SKEY  = 4'd7;
  localparam logic [3:0] ST_SKEYW = 4'd8;
  localparam logic [3:0] ST_SCRD  = 4'd9;
  localparam logic [3:0] ST_SCMP  = 4'd10;
  localparam logic [3:0] ST_SPUT  = 4'd11;
  localparam logic [3:0] ST_LRD   = 4'd12;
  localparam logic [3:0] ST_LOUT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_EMIT;
        case (sts.func)
          FN_PUSH_FRONT: begin
            if (sts.full) begin
              cmd.drop_set = 1'b1;
            end else begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = ADDR_NEWHEAD;
              cmd.head_op  = HEAD_DEC;
              cmd.occ_op   = OCC_INC;
            end
          end
          FN_PUSH_BACK: begin
            if (sts.full) begin
              cmd.drop_set = 1'b1;
            end else begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = ADDR_TAIL;
              cmd.occ_op   = OCC_INC;
            end
          end
          FN_POP_FRONT: begin
            if (sts.empty) begin
              cmd.drop_set = 1'b1;
            end else begin
              cmd.head_op = HEAD_INC;
              cmd.occ_op  = OCC_DEC;
            end
          end
          FN_POP_BACK: begin
            if (sts.empty) begin
              cmd.drop_set = 1'b1;
            end else begin
              cmd.occ_op = OCC_DEC;
            end
          end
          FN_FRONT: begin
            cmd.mem_rd   = !sts.empty;
            cmd.addr_sel = ADDR_HEAD;
          end
          FN_BACK: begin
            cmd.mem_rd   = !sts.empty;
            cmd.addr_sel = ADDR_BACK;
          end
          FN_CLEAR: begin
            cmd.head_op = HEAD_ZERO;
            cmd.occ_op  = OCC_ZERO;
          end
          FN_REVERSE: begin
            if (sts.occ_gt1) begin
              cmd.i_op  = I_ZERO;
              cmd.j_op  = J_LAST;
              state_nxt = ST_R1;
            end
          end
          FN_SORT: begin
            if (sts.occ_gt1) begin
              cmd.i_op  = I_ONE;
              state_nxt = ST_SKEY;
            end
          end
          FN_LIST: begin
            if (!sts.empty) begin
              cmd.i_op  = I_ZERO;
              state_nxt = ST_LRD;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      // Reverse: swap the words at offsets i and j, then close in.
      ST_R1: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_I;
        state_nxt    = ST_R2;
      end
      ST_R2: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_J;
        cmd.tmp_load = 1'b1;
        state_nxt    = ST_R3;
      end
      ST_R3: begin
        cmd.mem_wr    = 1'b1;
        cmd.addr_sel  = ADDR_I;
        cmd.wdata_sel = WD_RDATA;
        state_nxt     = ST_R4;
      end
      ST_R4: begin
        cmd.mem_wr    = 1'b1;
        cmd.addr_sel  = ADDR_J;
        cmd.wdata_sel = WD_TMP;
        cmd.i_op      = I_INC;
        cmd.j_op      = J_DEC;
        state_nxt     = sts.rev_more ? ST_R1 : ST_EMIT;
      end
      // Insertion sort: take key at i, shift larger words up, place key.
      ST_SKEY: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_I;
        state_nxt    = ST_SKEYW;
      end
      ST_SKEYW: begin
        cmd.key_load = 1'b1;
        cmd.j_op     = J_FROM_I;
        state_nxt    = ST_SCRD;
      end
      ST_SCRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_JM1;
        state_nxt    = ST_SCMP;
      end
      ST_SCMP: begin
        if (sts.key_less) begin
          cmd.mem_wr    = 1'b1;
          cmd.addr_sel  = ADDR_J;
          cmd.wdata_sel = WD_RDATA;
          cmd.j_op      = J_DEC;
          state_nxt     = sts.j_is1 ? ST_SPUT : ST_SCRD;
        end else begin
          state_nxt = ST_SPUT;
        end
      end
      ST_SPUT: begin
        cmd.mem_wr    = 1'b1;
        cmd.addr_sel  = ADDR_J;
        cmd.wdata_sel = WD_KEY;
        if (sts.sort_more) begin
          cmd.i_op  = I_INC;
          state_nxt = ST_SKEY;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      // List: read offset i, transfer it, advance.
      ST_LRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_I;
        state_nxt    = ST_LOUT;
      end
      ST_LOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_list = 1'b1;
          if (sts.list_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.i_op  = I_INC;
            state_nxt = ST_LRD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
